### rtl/sitda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for the decimal text converter
// Holds the field widths, the ASCII codes, the place-value multiple table and
// the structs that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int NUM_PLACES = 10;
    localparam int RADIX      = 10;
    localparam int PLACE_W    = $clog2(NUM_PLACES);
    localparam int DIGIT_W    = $clog2(RADIX);
    localparam int MULT_W     = VALUE_W + 2;

    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
    localparam logic [PLACE_W-1:0] LAST_PLACE  = PLACE_W'(NUM_PLACES - 1);
    localparam logic [MULT_W-1:0]  TOP_WEIGHT  = MULT_W'(1000000000);

    // Row p holds k times the weight of decimal place p, billions first.
    typedef logic [NUM_PLACES-1:0][RADIX-1:0][MULT_W-1:0] mult_tbl_t;

    function automatic mult_tbl_t build_mult();
        mult_tbl_t          tbl;
        logic [MULT_W-1:0]  weight;
        weight = TOP_WEIGHT;
        for (int p = 0; p < NUM_PLACES; p++)
        begin
            for (int k = 0; k < RADIX; k++)
            begin
                tbl[p][k] = weight * MULT_W'(k);
            end
            weight = weight / MULT_W'(RADIX);
        end
        return tbl;
    endfunction

    localparam mult_tbl_t PLACE_MULT = build_mult();

    // One classified number: sign and unsigned magnitude.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } work_t;

    typedef struct packed {
        logic  push;
        work_t item;
    } push_t;

    typedef struct packed {
        logic  valid;
        work_t item;
    } head_t;

endpackage
`default_nettype wire

### rtl/sitda_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_in_if: number channel
// Carries one signed 32-bit integer per transaction with valid and ready.
// ----------------------------------------------------------------------------
interface sitda_in_if import sitda_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

### rtl/sitda_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_out_if: character channel
// Carries one ASCII character per transaction, flagged on the final one.
// ----------------------------------------------------------------------------
interface sitda_out_if import sitda_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

### rtl/sitda_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_front: number intake
// Accepts numbers while the queue has room and splits each into a sign flag
// and a 32-bit unsigned magnitude.
// ----------------------------------------------------------------------------
module sitda_front import sitda_pkg::*;
(
    sitda_in_if.sink number,
    input  logic     full,
    output push_t    push
);

    logic [VALUE_W-1:0] raw;

    assign raw          = VALUE_W'(number.value);
    assign number.ready = !full;

    always_comb
    begin
        push.push     = number.valid && !full;
        push.item.neg = raw[VALUE_W-1];
        // The most negative value negates to 2^31, which fits unsigned.
        push.item.mag = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
    end

endmodule
`default_nettype wire

### rtl/sitda_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_queue: two-entry queue
// Holds classified numbers between the front end and the digit back end so
// that each side can stall on its own.
// ----------------------------------------------------------------------------
module sitda_queue import sitda_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output logic  full,
    output head_t head
);

    work_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push.push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_ptr_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

### rtl/sitda_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_back: digit sequencer
// Walks the ten decimal places of one magnitude, one place per cycle while the
// character output is not stalled, and drives the character register with the minus sign and the nonzero-led digits.
// ----------------------------------------------------------------------------
module sitda_back import sitda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  head_t       head,
    output logic        pop,
    sitda_out_if.source text
);

    logic                      busy_reg, busy_next;
    logic                      neg_reg, neg_next;
    logic                      started_reg, started_next;
    logic [PLACE_W-1:0]        place_reg, place_next;
    logic [VALUE_W-1:0]        mag_reg, mag_next;
    logic                      valid_reg, valid_next;
    logic [CHAR_W-1:0]         character_reg, character_next;
    logic                      last_reg, last_next;

    logic [RADIX-1:0][MULT_W-1:0] row;
    logic [DIGIT_W-1:0]        digit;
    logic                      step;
    logic                      emit;
    logic                      finish;

    assign text.valid     = valid_reg;
    assign text.character = character_reg;
    assign text.last      = last_reg;

    // Digit of the current place: the largest k with k * weight <= magnitude.
    always_comb
    begin
        row   = PLACE_MULT[place_reg];
        digit = '0;
        for (int k = 1; k < RADIX; k++)
        begin
            if ({2'b00, mag_reg} >= row[k])
            begin
                digit = DIGIT_W'(k);
            end
        end
    end

    always_comb
    begin
        step   = busy_reg && (!valid_reg || text.ready);
        emit   = (digit != '0) || started_reg || (place_reg == LAST_PLACE);
        finish = step && !neg_reg && (place_reg == LAST_PLACE);
        pop    = head.valid && (!busy_reg || finish);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        place_next     = place_reg;
        mag_next       = mag_reg;
        valid_next     = valid_reg && !text.ready;
        character_next = character_reg;
        last_next      = last_reg;

        if (step)
        begin
            if (neg_reg)
            begin
                neg_next       = 1'b0;
                valid_next     = 1'b1;
                character_next = ASCII_MINUS;
                last_next      = 1'b0;
            end
            else
            begin
                mag_next     = mag_reg - row[digit][VALUE_W-1:0];
                place_next   = place_reg + PLACE_W'(1);
                started_next = started_reg || emit;
                if (emit)
                begin
                    valid_next     = 1'b1;
                    character_next = ASCII_ZERO + CHAR_W'(digit);
                    last_next      = (place_reg == LAST_PLACE);
                end
                if (place_reg == LAST_PLACE)
                begin
                    busy_next = 1'b0;
                end
            end
        end

        // The next number loads in the same cycle that the units digit leaves.
        if (pop)
        begin
            busy_next    = 1'b1;
            neg_next     = head.item.neg;
            mag_next     = head.item.mag;
            place_next   = '0;
            started_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            neg_reg     <= 1'b0;
            started_reg <= 1'b0;
            place_reg   <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            neg_reg     <= neg_next;
            started_reg <= started_next;
            place_reg   <= place_next;
            valid_reg   <= valid_next;
        end
    end

    a_place_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (place_reg <= LAST_PLACE))
        else $error("place counter beyond units");

    a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && neg_reg) |-> (place_reg == '0 && !started_reg))
        else $error("minus sign pending after digits began");

    a_units_emit: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (valid_reg && last_reg))
        else $error("units digit did not close the number");

endmodule
`default_nettype wire

### rtl/signed_int_to_decimal_ascii.sv
// Each number taken is written into the two-entry queue, then loaded into the digit
// sequencer, which puts the minus sign and then one decimal place per step into the output
// register; leading zero places give no character, and a stalled output holds the sequencer.
// The queue takes new numbers while it has room and the sequencer works, and the next number
// loads as the units digit of the last one leaves.
// Reset is asynchronous and active low; it empties the queue and the output.
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal text
// Converts each signed 32-bit number into its decimal ASCII characters,
// minus sign first, leading zeros dropped, last character flagged.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii import sitda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sitda_in_if.sink    number,
    sitda_out_if.source text
);

    push_t push;
    head_t head;
    logic  full;
    logic  pop;

    sitda_front u_front
    (
        .number (number),
        .full   (full),
        .push   (push)
    );

    sitda_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (full),
        .head  (head)
    );

    sitda_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .text  (text)
    );

endmodule
`default_nettype wire

### tb/sv/decimal_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_text_checker: predictor and scoreboard for the decimal text converter
// Watches the number and character channels. Each accepted number is expanded
// into the characters it must produce, and every character transaction is
// compared field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module decimal_text_checker import sitda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sitda_in_if         number,
    sitda_out_if        text,
    output int unsigned mismatches,
    output int unsigned chars_outstanding
);

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    text_char_t expected_text[$];

    // Sign first, then the ten places from billions down, with leading zeros
    // dropped; the units place is always printed so that zero gives one digit.
    function automatic void expand_decimal(input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] weight;
        logic [3:0]         digit;
        bit                 started;
        text_char_t         row[$];
        text_char_t         c;
        started = 1'b0;
        // The unsigned negation also covers the most negative value.
        mag = v[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(v)) : VALUE_W'(v);
        if (v[VALUE_W-1])
        begin
            c.code = ASCII_MINUS;
            c.last = 1'b0;
            row.push_back(c);
        end
        weight = VALUE_W'(1000000000);
        for (int p = 0; p < NUM_PLACES; p++)
        begin
            digit = 4'(mag / weight);
            mag   = mag % weight;
            if (digit != 4'd0 || started || p == NUM_PLACES - 1)
            begin
                started = 1'b1;
                c.code  = ASCII_ZERO + CHAR_W'(digit);
                c.last  = 1'b0;
                row.push_back(c);
            end
            weight = weight / VALUE_W'(RADIX);
        end
        row[row.size() - 1].last = 1'b1;
        foreach (row[i])
            expected_text.push_back(row[i]);
    endfunction

    initial
    begin
        mismatches        = 0;
        chars_outstanding = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text.valid && text.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected character: got 0x%02h last %0b",
                             $time, text.character, text.last);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    if (text.character !== expected_text[0].code
                        || text.last !== expected_text[0].last)
                    begin
                        $display("%0t: character mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                                 $time, expected_text[0].code, expected_text[0].last,
                                 text.character, text.last);
                        mismatches = mismatches + 1;
                    end
                    void'(expected_text.pop_front());
                end
            end
            if (number.valid && number.ready)
                expand_decimal(number.value);
            chars_outstanding = expected_text.size();
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the signed integer to decimal text converter
// Drives directed and random numbers with random gaps, stalls the character
// side at random and once for a long stretch, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench import sitda_pkg::*;
();

    localparam int unsigned RANDOM_NUMBERS = 300;
    localparam int unsigned CYCLE_LIMIT    = 1000000;
    localparam int unsigned HOLD_START     = 1500;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned CALM_START     = 3000;
    localparam int unsigned CALM_END       = 3600;
    localparam int unsigned TAIL_CYCLES    = 20;

    logic        clk;
    logic        rst_n;
    int unsigned mismatches;
    int unsigned chars_left;

    sitda_in_if  number_ch();
    sitda_out_if text_ch();

    signed_int_to_decimal_ascii dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .text   (text_ch)
    );

    decimal_text_checker text_check
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .number            (number_ch),
        .text              (text_ch),
        .mismatches        (mismatches),
        .chars_outstanding (chars_left)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Spreads values over every text length, the decade edges and both signs.
    function automatic logic signed [VALUE_W-1:0] random_number();
        int unsigned       roll;
        int unsigned       decade;
        longint unsigned   span;
        logic [VALUE_W-1:0] v;
        roll   = $urandom_range(0, 99);
        decade = $urandom_range(0, 9);
        span   = 1;
        for (int k = 0; k < decade; k++)
            span = span * 10;
        if (roll < 40)
            v = $urandom();
        else if (roll < 70)
            v = VALUE_W'($urandom_range(0, 32'(span * 2 - 1)));
        else if (roll < 85)
            v = VALUE_W'(span) + VALUE_W'($urandom_range(0, 2)) - VALUE_W'(1);
        else
            v = VALUE_W'($urandom_range(0, 20));
        if (roll >= 40 && $urandom_range(0, 1) == 1)
            v = VALUE_W'(0) - v;
        return v;
    endfunction

    task automatic send_number(input logic signed [VALUE_W-1:0] v, input bit no_gap);
        int unsigned gap;
        number_ch.valid <= 1'b1;
        number_ch.value <= v;
        do
            @(posedge clk);
        while (!number_ch.ready);
        gap = no_gap ? 0 : idle_gap();
        if (gap != 0)
        begin
            number_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : source_side
        logic signed [VALUE_W-1:0] directed[$];
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                     32'sd7, -32'sd7, 32'sd100, 32'sd12345, -32'sd100000,
                     32'sd1000000, 32'sd999999999, 32'sd1000000000,
                     -32'sd1000000000, 32'sd2000000000, 32'sh7FFFFFFF,
                     32'sh80000000, 32'sh80000001, 32'sh55555555, 32'shAAAAAAAA,
                     32'sd1000000001, -32'sd999999999};
        rst_n           = 1'b0;
        number_ch.valid = 1'b0;
        number_ch.value = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_number(directed[i], 1'b0);
        for (int unsigned n = 0; n < RANDOM_NUMBERS; n++)
            send_number(random_number(), n >= 120 && n < 180);
        number_ch.valid <= 1'b0;
        // Let the checker take in the final transaction before counting what is left.
        @(posedge clk);
        while (chars_left != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && chars_left == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : sink_side
        int unsigned cycle;
        int unsigned stall_left;
        cycle         = 0;
        stall_left    = 0;
        text_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle = cycle + 1;
            // One long hold-off lets the queue fill so the number side stalls.
            if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
                text_ch.ready <= 1'b0;
            else if (stall_left != 0)
            begin
                text_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                text_ch.ready <= 1'b1;
                if (!(cycle >= CALM_START && cycle < CALM_END)
                    && $urandom_range(0, 3) == 0)
                    stall_left = idle_gap();
            end
        end
    end

    initial
    begin : watchdog
        for (int unsigned c = 0; c < CYCLE_LIMIT; c++)
            @(posedge clk);
        $display("%0t: cycle limit reached", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/sitda_pkg.sv
rtl/sitda_in_if.sv
rtl/sitda_out_if.sv
rtl/sitda_front.sv
rtl/sitda_queue.sv
rtl/sitda_back.sv
rtl/signed_int_to_decimal_ascii.sv
tb/sv/decimal_text_checker.sv
tb/sv/testbench.sv
